// ===== rtl/core/bpc_pkg.sv =====
// Shared widths, constants, register codes and stage payload types.
package bpc_pkg;

	// Field widths
	localparam int RAW_W     = 24;
	localparam int CAL_W     = 16;
	localparam int TEMP_W    = 19;
	localparam int PRES_W    = 32;
	localparam int CFG_IDX_W = 3;

	// Internal value widths, sized to the reachable ranges
	localparam int DT_W    = RAW_W + 1;
	localparam int PROD_W  = DT_W + CAL_W + 1;
	localparam int DTSQ_W  = 2 * DT_W;
	localparam int OFF_W   = 35;
	localparam int SENS_W  = 34;
	localparam int T2_W    = 18;
	localparam int SQ_W    = 35;
	localparam int TSQ_W   = 2 * TEMP_W;
	localparam int OFF2_W  = 38;
	localparam int SENS2_W = 37;
	localparam int OFFC_W  = 39;
	localparam int SENSC_W = 38;
	localparam int SPLIT_W = 19;
	localparam int HI_W    = SENSC_W - SPLIT_W;
	localparam int LOP_W   = RAW_W + SPLIT_W;
	localparam int HIP_W   = RAW_W + 1 + HI_W;
	localparam int FULL_W  = 63;

	// Shift amounts of the compensation formula
	localparam int REF_SHIFT       = 8;
	localparam int TEMP_SHIFT      = 23;
	localparam int OFF_SHIFT       = 7;
	localparam int SENS_SHIFT      = 8;
	localparam int OFF_BASE_SHIFT  = 16;
	localparam int SENS_BASE_SHIFT = 15;
	localparam int T2_SHIFT        = 31;
	localparam int PMUL_SHIFT      = 21;
	localparam int PRES_SHIFT      = 15;

	// Temperature thresholds in hundredths of a degree
	localparam logic signed [TEMP_W-1:0] TEMP_REF  = 19'sd2000;
	localparam logic signed [TEMP_W-1:0] TEMP_COLD = -19'sd1500;

	// Second-order correction factors
	localparam logic [OFF2_W-1:0] K_OFF_LOW   = 38'd5;
	localparam logic [OFF2_W-1:0] K_OFF_COLD  = 38'd7;
	localparam logic [OFF2_W-1:0] K_SENS_LOW  = 38'd5;
	localparam logic [OFF2_W-1:0] K_SENS_COLD = 38'd11;

	// Calibration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SENS      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OFF       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SENS_TC   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_OFF_TC    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_TREF      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_TEMP_COEF = 3'd5;

	typedef struct packed {
		logic [CAL_W-1:0] sens;
		logic [CAL_W-1:0] off;
		logic [CAL_W-1:0] sens_tc;
		logic [CAL_W-1:0] off_tc;
		logic [CAL_W-1:0] tref;
		logic [CAL_W-1:0] tc;
	} cal_t;

	// First-order results handed to the correction stages
	typedef struct packed {
		logic signed [TEMP_W-1:0] temp;
		logic signed [OFF_W-1:0]  off;
		logic signed [SENS_W-1:0] sens;
		logic [T2_W-1:0]          t2;
		logic [RAW_W-1:0]         d1;
	} front_t;

	// Corrected terms handed to the pressure stages
	typedef struct packed {
		logic signed [TEMP_W-1:0]  temp;
		logic signed [OFFC_W-1:0]  off;
		logic signed [SENSC_W-1:0] sens;
		logic [RAW_W-1:0]          d1;
	} corr_t;

endpackage

// ===== rtl/core/bpc_chan_if.sv =====
// Channel interfaces for raw conversion words and compensated result words.
interface bpc_in_if;
	logic                       valid;
	logic                       ready;
	logic [bpc_pkg::RAW_W-1:0]  raw_pressure;
	logic [bpc_pkg::RAW_W-1:0]  raw_temperature;

	modport source(output valid, output raw_pressure, output raw_temperature, input ready);
	modport sink(input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

interface bpc_out_if;
	logic                              valid;
	logic                              ready;
	logic signed [bpc_pkg::TEMP_W-1:0] temp_centi;
	logic signed [bpc_pkg::PRES_W-1:0] pressure_pa;

	modport source(output valid, output temp_centi, output pressure_pa, input ready);
	modport sink(input valid, input temp_centi, input pressure_pa, output ready);
endinterface

// ===== rtl/core/bpc_front.sv =====
// First-order stages: temperature difference, coefficient products, TEMP/OFF/SENS and T2.
module bpc_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  bpc_pkg::cal_t             cal,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [bpc_pkg::RAW_W-1:0] raw_p,
	input  logic [bpc_pkg::RAW_W-1:0] raw_t,
	output logic                      out_valid,
	input  logic                      out_ready,
	output bpc_pkg::front_t           out_data
);
	import bpc_pkg::*;

	logic v_s1, v_s2, v_s3;
	logic adv_s1, adv_s2, adv_s3;

	logic signed [DT_W-1:0]   dt_s1;
	logic [RAW_W-1:0]         d1_s1, d1_s2;
	logic signed [PROD_W-1:0] tc_prod_s2, off_prod_s2, sens_prod_s2;
	logic signed [DTSQ_W-1:0] dtsq_s2;
	front_t                   res_s3;

	logic signed [CAL_W:0]    tc_sx, off_tc_sx, sens_tc_sx;
	logic signed [PROD_W-1:0] tc_sh, off_sh, sens_sh;

	assign adv_s3   = !v_s3 || out_ready;
	assign adv_s2   = !v_s2 || adv_s3;
	assign adv_s1   = !v_s1 || adv_s2;
	assign in_ready = adv_s1;

	assign out_valid = v_s3;
	assign out_data  = res_s3;

	assign tc_sx      = $signed({1'b0, cal.tc});
	assign off_tc_sx  = $signed({1'b0, cal.off_tc});
	assign sens_tc_sx = $signed({1'b0, cal.sens_tc});

	assign tc_sh   = tc_prod_s2 >>> TEMP_SHIFT;
	assign off_sh  = off_prod_s2 >>> OFF_SHIFT;
	assign sens_sh = sens_prod_s2 >>> SENS_SHIFT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= in_valid;
			if (adv_s2) v_s2 <= v_s1;
			if (adv_s3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			dt_s1 <= $signed({1'b0, raw_t}) - $signed({1'b0, cal.tref, {REF_SHIFT{1'b0}}});
			d1_s1 <= raw_p;
		end
		if (adv_s2) begin
			tc_prod_s2   <= dt_s1 * tc_sx;
			off_prod_s2  <= dt_s1 * off_tc_sx;
			sens_prod_s2 <= dt_s1 * sens_tc_sx;
			dtsq_s2      <= dt_s1 * dt_s1;
			d1_s2        <= d1_s1;
		end
		if (adv_s3) begin
			res_s3.temp <= TEMP_REF + $signed(tc_sh[TEMP_W-1:0]);
			res_s3.off  <= $signed({{(OFF_W-CAL_W-OFF_BASE_SHIFT){1'b0}}, cal.off,
				{OFF_BASE_SHIFT{1'b0}}}) + $signed(off_sh[OFF_W-1:0]);
			res_s3.sens <= $signed({{(SENS_W-CAL_W-SENS_BASE_SHIFT){1'b0}}, cal.sens,
				{SENS_BASE_SHIFT{1'b0}}}) + $signed(sens_sh[SENS_W-1:0]);
			// The square is never negative and stays below 2^48.
			res_s3.t2   <= dtsq_s2[T2_SHIFT +: T2_W];
			res_s3.d1   <= d1_s2;
		end
	end

endmodule

// ===== rtl/core/bpc_corr.sv =====
// Second-order correction stages for low and very low temperatures.
module bpc_corr (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  bpc_pkg::front_t in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output bpc_pkg::corr_t  out_data
);
	import bpc_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4;
	logic adv_s1, adv_s2, adv_s3, adv_s4;

	logic signed [TEMP_W-1:0] x_low_s1, x_cold_s1;
	logic                     low_s1, cold_s1, low_s2, cold_s2;
	logic signed [TEMP_W-1:0] temp_s1, temp_s2, temp_s3;
	logic signed [OFF_W-1:0]  off_s1, off_s2, off_s3;
	logic signed [SENS_W-1:0] sens_s1, sens_s2, sens_s3;
	logic [RAW_W-1:0]         d1_s1, d1_s2, d1_s3;
	logic signed [TSQ_W-1:0]  sq_low_s2, sq_cold_s2;
	logic [OFF2_W-1:0]        off2_s3;
	logic [SENS2_W-1:0]       sens2_s3;
	corr_t                    res_s4;

	logic              in_low, in_cold;
	logic [OFF2_W-1:0] sq_low, sq_cold;
	logic [OFF2_W-1:0] off_a, off_b, sens_a, sens_b, sens2_sum;

	assign adv_s4   = !v_s4 || out_ready;
	assign adv_s3   = !v_s3 || adv_s4;
	assign adv_s2   = !v_s2 || adv_s3;
	assign adv_s1   = !v_s1 || adv_s2;
	assign in_ready = adv_s1;

	assign out_valid = v_s4;
	assign out_data  = res_s4;

	assign in_low  = in_data.temp < TEMP_REF;
	assign in_cold = in_data.temp < TEMP_COLD;

	// Both squares are below 2^35 in every reachable case.
	assign sq_low  = OFF2_W'(sq_low_s2[SQ_W-1:0]);
	assign sq_cold = OFF2_W'(sq_cold_s2[SQ_W-1:0]);

	assign off_a     = low_s2  ? ((sq_low * K_OFF_LOW) >> 1)   : '0;
	assign off_b     = cold_s2 ? (sq_cold * K_OFF_COLD)         : '0;
	assign sens_a    = low_s2  ? ((sq_low * K_SENS_LOW) >> 2)   : '0;
	assign sens_b    = cold_s2 ? ((sq_cold * K_SENS_COLD) >> 1) : '0;
	assign sens2_sum = sens_a + sens_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= in_valid;
			if (adv_s2) v_s2 <= v_s1;
			if (adv_s3) v_s3 <= v_s2;
			if (adv_s4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			x_low_s1  <= in_data.temp - TEMP_REF;
			x_cold_s1 <= in_data.temp - TEMP_COLD;
			low_s1    <= in_low;
			cold_s1   <= in_cold;
			// The reported temperature takes the T2 term but the thresholds do not.
			temp_s1   <= in_data.temp - (in_low ? $signed({1'b0, in_data.t2}) : '0);
			off_s1    <= in_data.off;
			sens_s1   <= in_data.sens;
			d1_s1     <= in_data.d1;
		end
		if (adv_s2) begin
			sq_low_s2  <= x_low_s1 * x_low_s1;
			sq_cold_s2 <= x_cold_s1 * x_cold_s1;
			low_s2     <= low_s1;
			cold_s2    <= cold_s1;
			temp_s2    <= temp_s1;
			off_s2     <= off_s1;
			sens_s2    <= sens_s1;
			d1_s2      <= d1_s1;
		end
		if (adv_s3) begin
			off2_s3  <= off_a + off_b;
			sens2_s3 <= sens2_sum[SENS2_W-1:0];
			temp_s3  <= temp_s2;
			off_s3   <= off_s2;
			sens_s3  <= sens_s2;
			d1_s3    <= d1_s2;
		end
		if (adv_s4) begin
			res_s4.temp <= temp_s3;
			res_s4.off  <= OFFC_W'(off_s3) - $signed({1'b0, off2_s3});
			res_s4.sens <= SENSC_W'(sens_s3) - $signed({1'b0, sens2_s3});
			res_s4.d1   <= d1_s3;
		end
	end

endmodule

// ===== rtl/core/bpc_press.sv =====
// Pressure stages: split raw-times-sensitivity product, offset removal and scaling.
module bpc_press (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  bpc_pkg::corr_t                    in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [bpc_pkg::TEMP_W-1:0] temp_centi,
	output logic signed [bpc_pkg::PRES_W-1:0] pressure_pa
);
	import bpc_pkg::*;

	logic v_s1, v_s2, v_s3;
	logic adv_s1, adv_s2, adv_s3;

	logic [LOP_W-1:0]         lo_prod_s1;
	logic signed [HIP_W-1:0]  hi_prod_s1;
	logic signed [FULL_W-1:0] full_s2;
	logic signed [OFFC_W-1:0] off_s1, off_s2;
	logic signed [TEMP_W-1:0] temp_s1, temp_s2, temp_s3;
	logic signed [PRES_W-1:0] pres_s3;

	logic signed [FULL_W-1:0] scaled, diff, pres_full;

	assign adv_s3   = !v_s3 || out_ready;
	assign adv_s2   = !v_s2 || adv_s3;
	assign adv_s1   = !v_s1 || adv_s2;
	assign in_ready = adv_s1;

	assign out_valid   = v_s3;
	assign temp_centi  = temp_s3;
	assign pressure_pa = pres_s3;

	assign scaled    = full_s2 >>> PMUL_SHIFT;
	assign diff      = scaled - FULL_W'(off_s2);
	assign pres_full = diff >>> PRES_SHIFT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= in_valid;
			if (adv_s2) v_s2 <= v_s1;
			if (adv_s3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			// Sensitivity is split into a signed upper half and an unsigned lower half.
			lo_prod_s1 <= LOP_W'(in_data.d1) * LOP_W'(in_data.sens[SPLIT_W-1:0]);
			hi_prod_s1 <= $signed({1'b0, in_data.d1}) * $signed(in_data.sens[SENSC_W-1:SPLIT_W]);
			off_s1     <= in_data.off;
			temp_s1    <= in_data.temp;
		end
		if (adv_s2) begin
			full_s2 <= (FULL_W'(hi_prod_s1) <<< SPLIT_W) + $signed(FULL_W'(lo_prod_s1));
			off_s2  <= off_s1;
			temp_s2 <= temp_s1;
		end
		if (adv_s3) begin
			pres_s3 <= pres_full[PRES_W-1:0];
			temp_s3 <= temp_s2;
		end
	end

endmodule

// ===== rtl/core/baro_pressure_compensation.sv =====
// Top level of the barometric pressure compensation pipeline.
//
// The block turns one pair of raw 24-bit sensor conversions into a compensated
// temperature in hundredths of a degree and a pressure in pascals, applying the
// second-order correction below 20.00 C and the extra term below -15.00 C.
// Words arrive on the raw channel (raw_pressure, raw_temperature) and leave on
// the comp channel (temp_centi, pressure_pa); a word moves on a rising edge at
// which valid and ready are both high.
// The six calibration words are written through cfg_we, cfg_idx and cfg_wdata,
// one register per edge; the user must write them only while no word is in
// flight; the block does not check this. Indexes past the last register are ignored.
// Three stages form the first-order terms, four stages apply the correction
// and three stages build the pressure, the last of which is the output
// register. One word enters per cycle while the receiver takes results; each
// stage multiplier takes a new operand every cycle in which its stage advances.
// When the receiver stalls, each stage holds its word while later stages are
// full; empty stages still fill, so up to ten words can be taken before
// raw.ready falls. Nothing is lost or repeated.
// Reset clears every valid bit and all calibration words to zero.
module baro_pressure_compensation (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bpc_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [bpc_pkg::CAL_W-1:0]     cfg_wdata,
	bpc_in_if.sink                        raw,
	bpc_out_if.source                     comp
);
	import bpc_pkg::*;

	cal_t   cal_q;
	logic   front_valid, front_ready;
	front_t front_data;
	logic   corr_valid, corr_ready;
	corr_t  corr_data;

	// Calibration registers; the datapath reads them directly, so the user must
	// change them only while the pipeline is empty (the block does not check this).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_SENS:      cal_q.sens    <= cfg_wdata;
				CFG_OFF:       cal_q.off     <= cfg_wdata;
				CFG_SENS_TC:   cal_q.sens_tc <= cfg_wdata;
				CFG_OFF_TC:    cal_q.off_tc  <= cfg_wdata;
				CFG_TREF:      cal_q.tref    <= cfg_wdata;
				CFG_TEMP_COEF: cal_q.tc      <= cfg_wdata;
				default: ;
			endcase
		end
	end

	bpc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cal       (cal_q),
		.in_valid  (raw.valid),
		.in_ready  (raw.ready),
		.raw_p     (raw.raw_pressure),
		.raw_t     (raw.raw_temperature),
		.out_valid (front_valid),
		.out_ready (front_ready),
		.out_data  (front_data)
	);

	bpc_corr u_corr (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.in_ready  (front_ready),
		.in_data   (front_data),
		.out_valid (corr_valid),
		.out_ready (corr_ready),
		.out_data  (corr_data)
	);

	bpc_press u_press (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (corr_valid),
		.in_ready    (corr_ready),
		.in_data     (corr_data),
		.out_valid   (comp.valid),
		.out_ready   (comp.ready),
		.temp_centi  (comp.temp_centi),
		.pressure_pa (comp.pressure_pa)
	);

endmodule

// ===== rtl/core/bpc_chk.sv =====
// Port-level checker for the compensation pipeline, bound to the top level.
module bpc_chk (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              raw_ready,
	input logic                              comp_valid,
	input logic                              comp_ready,
	input logic signed [bpc_pkg::TEMP_W-1:0] temp_centi,
	input logic signed [bpc_pkg::PRES_W-1:0] pressure_pa
);
	import bpc_pkg::*;

	// The pipeline holds no word while reset is applied.
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !comp_valid)
		else $error("result word valid during reset");

	// A stalled result word stays put.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		comp_valid && !comp_ready |=> comp_valid && $stable(temp_centi)
			&& $stable(pressure_pa))
		else $error("stalled result word changed or vanished");

	// With the receiver ready every stage advances, so the input is ready too.
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		comp_ready |-> raw_ready)
		else $error("input stalled while output side is ready");

	// The corrected temperature always lands in its reachable range.
	a_temp_range: assert property (@(posedge clk) disable iff (!arst_n)
		comp_valid |-> (temp_centi >= -19'sd260142) && (temp_centi <= 19'sd133069))
		else $error("temperature out of range");

endmodule

bind baro_pressure_compensation bpc_chk u_bpc_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.raw_ready   (raw.ready),
	.comp_valid  (comp.valid),
	.comp_ready  (comp.ready),
	.temp_centi  (comp.temp_centi),
	.pressure_pa (comp.pressure_pa)
);
